>>> rtl/wisb_pkg.sv
`default_nettype none
package wisb_pkg;

  // default for the ssid store depth
  localparam int MAX_SSID_BYTES_DEF = 32;

  // configuration reset value
  localparam logic [7:0] CAP_RESET = 8'd129;

  // element ids and limits
  localparam logic [7:0] ID_SSID      = 8'd0;
  localparam logic [7:0] ID_LOAD      = 8'd11;
  localparam logic [7:0] LOAD_MIN_LEN = 8'd5;
  localparam logic [8:0] UNIT_MAX     = 9'd4;

  // result kinds
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // command operations from front to back
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_SSID = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  // depth of the command queue
  localparam int CMD_DEPTH = 2;

  // ascii codes used by the escaping
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_BSLSH = 8'h5c;
  localparam logic [7:0] CH_X     = 8'h78;

  // one finished element, an end of blob, or both
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] len;
    logic       all_zero;
    logic [7:0] load0;
    logic [7:0] load1;
    logic [7:0] load2;
    logic       has_end;
    logic       malformed;
  } cmd_t;

  // lowercase hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'd0, n};
    end else begin
      d = 8'h57 + {4'd0, n};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/wisb_front.sv
`default_nettype none
module wisb_front #(
  parameter int MAX_SSID_BYTES = 32,
  parameter int SSID_AW = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               in_tlast,
  output logic                    ssid_we,
  output logic [SSID_AW-1:0]      ssid_waddr,
  output logic [7:0]              ssid_wdata,
  output logic                    cmd_push,
  output wisb_pkg::cmd_t          cmd_data,
  input  wire logic               cmd_full,
  input  wire logic               ssid_done
);
  import wisb_pkg::*;

  localparam logic [1:0] PH_ID  = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  localparam logic [8:0] MAX_LEN = 9'(MAX_SSID_BYTES);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] eid_r, eid_nxt;
  logic [7:0] elen_r, elen_nxt;
  logic [7:0] pidx_r, pidx_nxt;
  logic       all_zero_r, all_zero_nxt;
  logic [7:0] ld0_r, ld0_nxt, ld1_r, ld1_nxt, ld2_r, ld2_nxt;
  logic       ssid_pend_r, ssid_pend_nxt;
  logic       acc;
  logic [1:0] op;
  logic [8:0] pidx_inc;

  // no new bytes while an ssid flush still reads the store
  assign in_tready = !cmd_full && !ssid_pend_r;
  assign acc = in_tvalid && in_tready;
  assign pidx_inc = {1'b0, pidx_r} + 9'd1;

  // element walk
  always_comb begin
    phase_nxt    = phase_r;
    eid_nxt      = eid_r;
    elen_nxt     = elen_r;
    pidx_nxt     = pidx_r;
    all_zero_nxt = all_zero_r;
    ld0_nxt      = ld0_r;
    ld1_nxt      = ld1_r;
    ld2_nxt      = ld2_r;
    op           = OP_NONE;
    ssid_we      = 1'b0;
    ssid_waddr   = pidx_r[SSID_AW-1:0];
    ssid_wdata   = in_tdata;
    if (acc) begin
      case (phase_r)
        PH_LEN: begin
          elen_nxt     = in_tdata;
          pidx_nxt     = 8'd0;
          all_zero_nxt = 1'b1;
          // zero-length element is complete here and never yields a result
          if (in_tdata == 8'd0) begin
            phase_nxt = PH_ID;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          if (eid_r == ID_SSID && {1'b0, elen_r} <= MAX_LEN &&
              {1'b0, pidx_r} < MAX_LEN) begin
            ssid_we = 1'b1;
            if (in_tdata != 8'd0) begin
              all_zero_nxt = 1'b0;
            end
          end
          if (eid_r == ID_LOAD) begin
            if (pidx_r == 8'd0) begin
              ld0_nxt = in_tdata;
            end
            if (pidx_r == 8'd1) begin
              ld1_nxt = in_tdata;
            end
            if (pidx_r == 8'd2) begin
              ld2_nxt = in_tdata;
            end
          end
          pidx_nxt = pidx_inc[7:0];
          if (pidx_inc >= {1'b0, elen_r}) begin
            phase_nxt = PH_ID;
            if (eid_r == ID_SSID && elen_r != 8'd0 && {1'b0, elen_r} <= MAX_LEN) begin
              op = OP_SSID;
            end else if (eid_r == ID_LOAD && elen_r >= LOAD_MIN_LEN) begin
              op = OP_LOAD;
            end
          end
        end
        default: begin
          eid_nxt   = in_tdata;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  // command to the back end
  always_comb begin
    cmd_push           = acc && (op != OP_NONE || in_tlast);
    cmd_data.op        = op;
    cmd_data.len       = elen_r;
    cmd_data.all_zero  = all_zero_nxt;
    cmd_data.load0     = ld0_nxt;
    cmd_data.load1     = ld1_nxt;
    cmd_data.load2     = ld2_nxt;
    cmd_data.has_end   = in_tlast;
    cmd_data.malformed = (phase_nxt != PH_ID);
  end

  // ssid pending flag
  always_comb begin
    ssid_pend_nxt = ssid_pend_r;
    if (ssid_done) begin
      ssid_pend_nxt = 1'b0;
    end
    if (cmd_push && op == OP_SSID) begin
      ssid_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ID;
      eid_r       <= 8'd0;
      elen_r      <= 8'd0;
      pidx_r      <= 8'd0;
      all_zero_r  <= 1'b1;
      ssid_pend_r <= 1'b0;
    end else begin
      ssid_pend_r <= ssid_pend_nxt;
      eid_r       <= eid_nxt;
      elen_r      <= elen_nxt;
      all_zero_r  <= all_zero_nxt;
      // end of blob restarts the walk
      if (acc && in_tlast) begin
        phase_r <= PH_ID;
        pidx_r  <= 8'd0;
      end else begin
        phase_r <= phase_nxt;
        pidx_r  <= pidx_nxt;
      end
    end
  end

  // load payload bytes
  always_ff @(posedge clk) begin
    ld0_r <= ld0_nxt;
    ld1_r <= ld1_nxt;
    ld2_r <= ld2_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/wisb_cmd_fifo.sv
`default_nettype none
module wisb_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wisb_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output wisb_pkg::cmd_t      dout,
  output logic                empty
);
  import wisb_pkg::*;

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_r [CMD_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wisb_back.sv
`default_nettype none
module wisb_back #(
  parameter int MAX_SSID_BYTES = 32,
  parameter int SSID_AW = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         capacity,
  input  wire logic               ssid_we,
  input  wire logic [SSID_AW-1:0] ssid_waddr,
  input  wire logic [7:0]         ssid_wdata,
  input  wire logic               cmd_empty,
  input  wire wisb_pkg::cmd_t     cmd_data,
  output logic                    cmd_pop,
  output logic                    ssid_done,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [63:0]             out_tdata,
  output logic [1:0]              out_tuser,
  output logic                    out_tlast
);
  import wisb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MARK = 3'd1;
  localparam logic [2:0] ST_UNIT = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  logic [7:0]         mem [MAX_SSID_BYTES];
  logic [7:0]         rd_data_r;
  logic [SSID_AW-1:0] rd_addr;

  logic [2:0]  st_r, st_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  used_r, used_nxt;
  logic        first_r, first_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  o_kind_r, o_kind_nxt;
  logic        o_start_r, o_start_nxt;
  logic [31:0] o_text_r, o_text_nxt;
  logic [2:0]  o_len_r, o_len_nxt;
  logic [15:0] o_sta_r, o_sta_nxt;
  logic [7:0]  o_chan_r, o_chan_nxt;
  logic        o_mal_r, o_mal_nxt;
  logic        o_last_r, o_last_nxt;

  logic        slot_free;
  logic        is_print, is_space;
  logic [31:0] u_text;
  logic [2:0]  u_len;
  logic [8:0]  used_sum;
  logic [8:0]  cnt_inc;
  logic        u_final;

  assign slot_free = !ov_r || out_tready;
  assign rd_addr   = cnt_nxt[SSID_AW-1:0];

  // ssid store, registered read
  always_ff @(posedge clk) begin
    if (ssid_we) begin
      mem[ssid_waddr] <= ssid_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // escaping of the current ssid byte
  always_comb begin
    is_print = (rd_data_r >= CH_BANG) && (rd_data_r <= CH_TILDE) && (rd_data_r != CH_BSLSH);
    is_space = (rd_data_r == CH_SPACE) && (cnt_r != 8'd0) && (cnt_r != cmd_r.len - 8'd1);
    if (is_print || is_space) begin
      u_text = {24'd0, rd_data_r};
      u_len  = 3'd1;
    end else begin
      u_text = {hex_digit(rd_data_r[3:0]), hex_digit(rd_data_r[7:4]), CH_X, CH_BSLSH};
      u_len  = 3'd4;
    end
    used_sum = {1'b0, used_r} + {6'd0, u_len};
    cnt_inc  = {1'b0, cnt_r} + 9'd1;
    u_final  = (cnt_inc >= {1'b0, cmd_r.len}) || (used_sum + UNIT_MAX >= {1'b0, capacity});
  end

  // sequencer and output register
  always_comb begin
    st_nxt      = st_r;
    cmd_nxt     = cmd_r;
    cnt_nxt     = cnt_r;
    used_nxt    = used_r;
    first_nxt   = first_r;
    cmd_pop     = 1'b0;
    ssid_done   = 1'b0;
    ov_nxt      = ov_r && !out_tready;
    o_kind_nxt  = o_kind_r;
    o_start_nxt = o_start_r;
    o_text_nxt  = o_text_r;
    o_len_nxt   = o_len_r;
    o_sta_nxt   = o_sta_r;
    o_chan_nxt  = o_chan_r;
    o_mal_nxt   = o_mal_r;
    o_last_nxt  = o_last_r;
    case (st_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_data;
          cnt_nxt   = 8'd0;
          used_nxt  = 8'd0;
          first_nxt = 1'b1;
          if (cmd_data.op == OP_SSID) begin
            // nothing fits or nothing to show: empty start marker only
            if (cmd_data.all_zero || {1'b0, capacity} <= UNIT_MAX) begin
              st_nxt = ST_MARK;
            end else begin
              st_nxt = ST_UNIT;
            end
          end else if (cmd_data.op == OP_LOAD) begin
            st_nxt = ST_LOAD;
          end else begin
            st_nxt = ST_END;
          end
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_TEXT;
          o_start_nxt = 1'b1;
          o_text_nxt  = 32'd0;
          o_len_nxt   = 3'd0;
          o_sta_nxt   = 16'd0;
          o_chan_nxt  = 8'd0;
          o_mal_nxt   = 1'b0;
          o_last_nxt  = !cmd_r.has_end;
          ssid_done   = 1'b1;
          st_nxt      = cmd_r.has_end ? ST_END : ST_IDLE;
        end
      end
      ST_UNIT: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_TEXT;
          o_start_nxt = first_r;
          o_text_nxt  = u_text;
          o_len_nxt   = u_len;
          o_sta_nxt   = 16'd0;
          o_chan_nxt  = 8'd0;
          o_mal_nxt   = 1'b0;
          o_last_nxt  = u_final && !cmd_r.has_end;
          first_nxt   = 1'b0;
          used_nxt    = used_sum[7:0];
          cnt_nxt     = cnt_inc[7:0];
          if (u_final) begin
            ssid_done = 1'b1;
            st_nxt    = cmd_r.has_end ? ST_END : ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_LOAD;
          o_start_nxt = 1'b0;
          o_text_nxt  = 32'd0;
          o_len_nxt   = 3'd0;
          o_sta_nxt   = {cmd_r.load1, cmd_r.load0};
          o_chan_nxt  = cmd_r.load2;
          o_mal_nxt   = 1'b0;
          o_last_nxt  = !cmd_r.has_end;
          st_nxt      = cmd_r.has_end ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_END;
          o_start_nxt = 1'b0;
          o_text_nxt  = 32'd0;
          o_len_nxt   = 3'd0;
          o_sta_nxt   = 16'd0;
          o_chan_nxt  = 8'd0;
          o_mal_nxt   = cmd_r.malformed;
          o_last_nxt  = 1'b1;
          st_nxt      = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      used_r <= 8'd0;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      used_r <= used_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cnt_r     <= cnt_nxt;
    first_r   <= first_nxt;
    o_kind_r  <= o_kind_nxt;
    o_start_r <= o_start_nxt;
    o_text_r  <= o_text_nxt;
    o_len_r   <= o_len_nxt;
    o_sta_r   <= o_sta_nxt;
    o_chan_r  <= o_chan_nxt;
    o_mal_r   <= o_mal_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'd0, o_mal_r, o_chan_r, o_sta_r, o_len_r, o_text_r, o_start_r};

endmodule
`default_nettype wire

>>> rtl/wlan_ie_ssid_bssload_parser.sv
// a byte's first result passes the command queue, the back-end command register and the
//   output register when the back end is idle
// throughput: 1 byte per cycle while the command queue has room and no ssid flush is pending;
//   the back end works on one command at a time and emits one result per ssid unit
// input is held off from an ssid command push until its last unit is registered
// reset: rst_n synchronous active low; walk restarts at an element id, capacity 129
`default_nettype none
module wlan_ie_ssid_bssload_parser #(
  parameter int MAX_SSID_BYTES = wisb_pkg::MAX_SSID_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,  // ssid_text_capacity
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // ie_byte
  input  wire logic        in_tlast,     // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // ssid_start[0], unit_text[32:1], unit_length[35:33], station_count[51:36],
  // channel_usage[59:52], malformed[60], zero[63:61]
  output logic [63:0]      out_tdata,
  output logic [1:0]       out_tuser,    // kind
  output logic             out_tlast     // last_of_run
);
  import wisb_pkg::*;

  localparam int SSID_AW = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;

  logic [7:0]         cap_r;
  logic               ssid_we;
  logic [SSID_AW-1:0] ssid_waddr;
  logic [7:0]         ssid_wdata;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t               cmd_in, cmd_out;
  logic               ssid_done;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  wisb_front #(
    .MAX_SSID_BYTES(MAX_SSID_BYTES),
    .SSID_AW(SSID_AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .ssid_we   (ssid_we),
    .ssid_waddr(ssid_waddr),
    .ssid_wdata(ssid_wdata),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full),
    .ssid_done (ssid_done)
  );

  wisb_cmd_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  wisb_back #(
    .MAX_SSID_BYTES(MAX_SSID_BYTES),
    .SSID_AW(SSID_AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .ssid_we   (ssid_we),
    .ssid_waddr(ssid_waddr),
    .ssid_wdata(ssid_wdata),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .ssid_done (ssid_done),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

>>> tb/sv/wlan_ie_ssid_bssload_parser_tb.sv
module wlan_ie_ssid_bssload_parser_tb;
  import wisb_pkg::*;

  localparam int SSID_MAX = MAX_SSID_BYTES_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PAUSE = 40;
  localparam int RANDOM_BYTES = 20;
  localparam int PRINT_CAP = 40;

  // walk phases of the predictor
  typedef enum logic [1:0] {WALK_ID, WALK_LEN, WALK_PAY} walk_phase_e;

  // one expected result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic        start;
    logic [31:0] text;
    logic [2:0]  ulen;
    logic [15:0] sta;
    logic [7:0]  chan;
    logic        mal;
    logic        last;
  } ie_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  wlan_ie_ssid_bssload_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predictor state
  walk_phase_e walk = WALK_ID;
  logic [7:0]  el_id = 8'd0;
  logic [7:0]  el_len = 8'd0;
  logic [7:0]  pay_idx = 8'd0;
  logic [7:0]  ssid_buf [0:SSID_MAX-1];
  logic        ssid_zero = 1'b1;
  logic [7:0]  load_buf [0:2];
  int          capacity = int'(CAP_RESET);

  ie_result_t  pending_results[$];
  ie_result_t  run_buf [0:63];
  int          run_cnt;
  logic [7:0]  blob_q[$];

  int          errors = 0;
  int          results_seen = 0;
  int          random_bytes = 0;
  int          burst_left = 0;
  int          cycles = 0;
  int          stall_cnt = 0;
  int          stall_mode = 0;
  ie_result_t  head_result;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // lowercase hex character of one nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h61 + {4'd0, n} - 8'd10;
  endfunction

  // append one result to the run of the current byte
  task add_result(input logic [1:0] kind, input logic start, input logic [31:0] text,
                  input logic [2:0] ulen, input logic [15:0] sta, input logic [7:0] chan,
                  input logic mal);
    ie_result_t r;
    r = '{kind: kind, start: start, text: text, ulen: ulen, sta: sta, chan: chan,
          mal: mal, last: 1'b0};
    run_buf[run_cnt] = r;
    run_cnt = run_cnt + 1;
  endtask

  // escaped ssid text units, bounded by the text capacity
  task flush_ssid;
    int         i;
    int         used;
    logic       first;
    logic [7:0] c;
    logic [31:0] txt;
    logic [2:0] ul;
    used = 0;
    first = 1'b1;
    if (!ssid_zero) begin
      for (i = 0; i < el_len && i < SSID_MAX; i++) begin
        c = ssid_buf[i];
        if (used + 4 >= capacity) break;
        if (c >= CH_BANG && c <= CH_TILDE && c != CH_BSLSH) begin
          txt = {24'd0, c};
          ul = 3'd1;
        end else if (c == CH_SPACE && i != 0 && i != el_len - 1) begin
          txt = {24'd0, CH_SPACE};
          ul = 3'd1;
        end else begin
          txt = {nibble_char(c[3:0]), nibble_char(c[7:4]), CH_X, CH_BSLSH};
          ul = 3'd4;
        end
        add_result(KIND_TEXT, first, txt, ul, 16'd0, 8'd0, 1'b0);
        first = 1'b0;
        used = used + int'(ul);
      end
    end
    if (first) add_result(KIND_TEXT, 1'b1, 32'd0, 3'd0, 16'd0, 8'd0, 1'b0);
  endtask

  // act on a complete element
  task finish_element;
    if (el_id == ID_SSID && el_len >= 1 && el_len <= SSID_MAX) begin
      flush_ssid();
    end else if (el_id == ID_LOAD && el_len >= LOAD_MIN_LEN) begin
      add_result(KIND_LOAD, 1'b0, 32'd0, 3'd0, {load_buf[1], load_buf[0]}, load_buf[2],
                 1'b0);
    end
    walk = WALK_ID;
  endtask

  // expected results of one accepted blob byte
  task predict_ie_byte(input logic [7:0] b, input logic l);
    int         i;
    ie_result_t r;
    run_cnt = 0;
    case (walk)
      WALK_LEN: begin
        el_len = b;
        pay_idx = 8'd0;
        ssid_zero = 1'b1;
        if (b == 8'd0) finish_element();
        else walk = WALK_PAY;
      end
      WALK_PAY: begin
        if (el_id == ID_SSID && el_len <= SSID_MAX && pay_idx < SSID_MAX) begin
          ssid_buf[pay_idx] = b;
          if (b != 8'd0) ssid_zero = 1'b0;
        end
        if (el_id == ID_LOAD && pay_idx < 3) load_buf[pay_idx] = b;
        pay_idx = pay_idx + 8'd1;
        if (pay_idx >= el_len) finish_element();
      end
      default: begin
        el_id = b;
        walk = WALK_LEN;
      end
    endcase
    if (l) begin
      add_result(KIND_END, 1'b0, 32'd0, 3'd0, 16'd0, 8'd0, walk != WALK_ID);
      walk = WALK_ID;
      pay_idx = 8'd0;
    end
    if (run_cnt > 0) begin
      r = run_buf[run_cnt-1];
      r.last = 1'b1;
      run_buf[run_cnt-1] = r;
    end
    for (i = 0; i < run_cnt; i++) pending_results.push_back(run_buf[i]);
  endtask

  // one input transaction, with bursts and random gaps in between
  task send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ie_byte(b, l);
  endtask

  // send the queued blob, last flag on its final byte
  task send_blob;
    int i;
    for (i = 0; i < blob_q.size(); i++) send_byte(blob_q[i], i == blob_q.size() - 1);
    blob_q.delete();
  endtask

  // element header into the blob queue
  task put_header(input logic [7:0] id, input logic [7:0] len);
    blob_q.push_back(id);
    blob_q.push_back(len);
  endtask

  // let the block drain before a register write
  task wait_idle;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task set_capacity(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = int'(v);
  endtask

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    errors = errors + 1;
    if (errors <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, field, got,
               want);
  endtask

  // escaping of printable, inner and outer spaces, backslash and high bytes
  task test_escaping;
    put_header(ID_SSID, 8'd10);
    blob_q.push_back(CH_SPACE);
    blob_q.push_back(8'h61);
    blob_q.push_back(CH_SPACE);
    blob_q.push_back(CH_BSLSH);
    blob_q.push_back(8'h7f);
    blob_q.push_back(CH_BANG);
    blob_q.push_back(CH_TILDE);
    blob_q.push_back(8'h00);
    blob_q.push_back(8'hff);
    blob_q.push_back(CH_SPACE);
    put_header(ID_SSID, 8'd3);
    blob_q.push_back(8'h80);
    blob_q.push_back(8'h5a);
    blob_q.push_back(8'h09);
    send_blob();
  endtask

  // all-zero ssid gives the empty marker; a lone space is escaped
  task test_all_zero_ssid;
    put_header(ID_SSID, 8'd3);
    repeat (3) blob_q.push_back(8'h00);
    put_header(ID_SSID, 8'd1);
    blob_q.push_back(CH_SPACE);
    send_blob();
  endtask

  // longest ssid, every byte escaped: most results from one byte
  task test_longest_ssid;
    int i;
    put_header(ID_SSID, 8'(SSID_MAX));
    for (i = 0; i < SSID_MAX; i++) blob_q.push_back(8'(i + 1));
    send_blob();
  endtask

  // elements that are skipped, and bss load reports
  task test_skipped_and_load;
    int i;
    put_header(ID_SSID, 8'd0);
    put_header(ID_SSID, 8'(SSID_MAX + 1));
    for (i = 0; i <= SSID_MAX; i++) blob_q.push_back(8'($urandom_range(0, 255)));
    put_header(ID_LOAD, 8'd4);
    repeat (4) blob_q.push_back(8'($urandom_range(0, 255)));
    put_header(8'hdd, 8'd0);
    put_header(ID_LOAD, 8'd5);
    blob_q.push_back(8'h34);
    blob_q.push_back(8'h12);
    blob_q.push_back(8'h56);
    blob_q.push_back(8'haa);
    blob_q.push_back(8'hbb);
    put_header(ID_LOAD, 8'd7);
    repeat (3) blob_q.push_back(8'hff);
    for (i = 3; i < 7; i++) blob_q.push_back(8'($urandom_range(0, 255)));
    put_header(ID_SSID, 8'd2);
    blob_q.push_back(8'h68);
    blob_q.push_back(8'h69);
    send_blob();
  endtask

  // blobs that end on an id, a length, mid payload, or on a complete element
  task test_truncation;
    blob_q.push_back(8'hdd);
    send_blob();
    put_header(ID_LOAD, 8'd5);
    send_blob();
    put_header(ID_SSID, 8'd6);
    blob_q.push_back(8'h61);
    blob_q.push_back(8'h62);
    send_blob();
    put_header(8'h30, 8'd0);
    send_blob();
  endtask

  // text capacity from too small for any unit to a few units
  task test_capacity;
    set_capacity(8'd1);
    put_header(ID_SSID, 8'd3);
    blob_q.push_back(8'h61);
    blob_q.push_back(8'h62);
    blob_q.push_back(8'h63);
    send_blob();
    set_capacity(8'd5);
    put_header(ID_SSID, 8'd3);
    blob_q.push_back(8'h61);
    blob_q.push_back(8'h62);
    blob_q.push_back(8'h63);
    send_blob();
    set_capacity(8'd9);
    put_header(ID_SSID, 8'd4);
    blob_q.push_back(8'h41);
    blob_q.push_back(8'h00);
    blob_q.push_back(8'h42);
    blob_q.push_back(8'h43);
    send_blob();
    set_capacity(CAP_RESET);
  endtask

  // random blobs of mostly well-formed elements, some noise and truncation
  task test_random_blobs;
    int n_el;
    int e;
    int k;
    int pick;
    int len;
    int keep;
    logic [7:0] c;
    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) set_capacity(8'd1);
        else if (pick == 1) set_capacity(8'd255);
        else set_capacity(8'($urandom_range(1, 255)));
      end
      n_el = $urandom_range(1, 4);
      for (e = 0; e < n_el; e++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
          if ($urandom_range(0, 9) != 0) len = $urandom_range(1, SSID_MAX);
          else if ($urandom_range(0, 1) == 0) len = 0;
          else len = $urandom_range(SSID_MAX + 1, SSID_MAX + 8);
          put_header(ID_SSID, 8'(len));
          for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) c = 8'($urandom_range(CH_BANG, CH_TILDE));
            else if (pick <= 6) c = CH_SPACE;
            else c = 8'($urandom_range(0, 255));
            blob_q.push_back(c);
          end
        end else if (pick <= 6) begin
          len = ($urandom_range(0, 6) != 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
          put_header(ID_LOAD, 8'(len));
          for (k = 0; k < len; k++) blob_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick <= 8) begin
          len = $urandom_range(0, 10);
          put_header(8'($urandom_range(0, 255)), 8'(len));
          for (k = 0; k < len; k++) blob_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(1, 10);
          for (k = 0; k < len; k++) blob_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        keep = $urandom_range(1, blob_q.size());
        while (blob_q.size() > keep) void'(blob_q.pop_back());
      end
      random_bytes = random_bytes + blob_q.size();
      send_blob();
    end
  endtask

  // receiver stalls on a pattern that changes mode now and then
  always @(posedge clk) begin
    stall_cnt = stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (stall_cnt % 4 == 0);
      default: out_tready <= (stall_cnt % 8 >= 3);
    endcase
  end

  // compare each output transaction with the oldest expected result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(out_tuser), 32'd0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_tuser !== head_result.kind)
          report_mismatch("kind", 32'(out_tuser), 32'(head_result.kind));
        if (out_tdata[0] !== head_result.start)
          report_mismatch("ssid_start", 32'(out_tdata[0]), 32'(head_result.start));
        if (out_tdata[32:1] !== head_result.text)
          report_mismatch("unit_text", out_tdata[32:1], head_result.text);
        if (out_tdata[35:33] !== head_result.ulen)
          report_mismatch("unit_length", 32'(out_tdata[35:33]), 32'(head_result.ulen));
        if (out_tdata[51:36] !== head_result.sta)
          report_mismatch("station_count", 32'(out_tdata[51:36]), 32'(head_result.sta));
        if (out_tdata[59:52] !== head_result.chan)
          report_mismatch("channel_usage", 32'(out_tdata[59:52]), 32'(head_result.chan));
        if (out_tdata[60] !== head_result.mal)
          report_mismatch("malformed", 32'(out_tdata[60]), 32'(head_result.mal));
        if (out_tdata[63:61] !== 3'd0)
          report_mismatch("pad bits", 32'(out_tdata[63:61]), 32'd0);
        if (out_tlast !== head_result.last)
          report_mismatch("last_of_run", 32'(out_tlast), 32'(head_result.last));
      end
      results_seen = results_seen + 1;
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles = cycles + 1;
    end
    $display("wlan_ie_ssid_bssload_parser verification failed");
    $finish;
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escaping();
    test_all_zero_ssid();
    test_longest_ssid();
    test_skipped_and_load();
    test_truncation();
    test_capacity();
    test_random_blobs();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    if (errors == 0) begin
      $display("wlan_ie_ssid_bssload_parser verification clean");
    end else begin
      $display("wlan_ie_ssid_bssload_parser verification failed");
    end
    $finish;
  end

endmodule

>>> wlan_ie_ssid_bssload_parser.f
rtl/wisb_pkg.sv
rtl/wisb_front.sv
rtl/wisb_cmd_fifo.sv
rtl/wisb_back.sv
rtl/wlan_ie_ssid_bssload_parser.sv
tb/sv/wlan_ie_ssid_bssload_parser_tb.sv
